[hw/rtl/ffba_pkg.sv]
// ---------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator
// Beat layouts of the request and response channels, status and mode
// codes, and configuration register indexes.
// ---------------------------------------------------------------------------
package ffba_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_BASE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_LIMIT = 1'd1;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [15:0] element_size;
      logic [15:0] element_count;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

endpackage

[hw/rtl/first_fit_block_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator with a break pointer
// Keeps a table of blocks in allocation order and serves allocate and
// free requests by scanning it one entry per cycle.
// ---------------------------------------------------------------------------
// Usage:
// A request beat (req_valid, req_data) is taken at an edge where req_valid
// is high and req_stall is low. Each request yields exactly one response
// beat on rsp_valid / rsp_data, taken when rsp_stall is low.
// The block serves one request at a time; req_stall stays high from the
// accepting edge until the response has been loaded into the output
// register. A scan that misses reads every entry in the table, and a hit
// on entry k stops there. The scan reads one entry per cycle from the entry
// memories and runs it through a single compare unit. The table holds
// TABLE_ENTRIES entries, 64 by default.
// The response register parts the two channels: a new request can be taken
// while the previous response still waits. If the receiver stalls, the
// finished result waits in the sequencer until the output register frees.
// Reset empties the table and loads the break pointer from heap_base (0).
// The configuration port (csr_*) is to be written only while the block is
// idle; the block itself does not enforce this. Writing heap_base while the
// table is empty also moves the break pointer.
// ---------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ffba_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ffba_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_enable,
   input  logic [ffba_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ffba_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import ffba_pkg::*;

   // Address width of the entry memories and width of the entry count,
   // which must be able to hold TABLE_ENTRIES itself.
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_APPEND = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // Sequencer and request registers.
   state_type     state_ff, state_in;
   logic          mode_ff, mode_in;
   logic [31:0]   req_size_ff, req_size_in;
   logic [31:0]   free_addr_ff, free_addr_in;

   // Scan control: next index to read, and whether the read data of the
   // previous cycle belongs to a valid entry.
   logic [CW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;

   // Allocator state.
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   break_ff, break_in;
   logic [31:0]   heap_base_ff, heap_base_in;
   logic [31:0]   heap_limit_ff, heap_limit_in;

   // Finished result, waiting for the output register.
   rsp_type       res_ff, res_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // Entry memories with registered read data.
   logic [31:0]   base_mem [TABLE_ENTRIES];
   logic [31:0]   size_mem [TABLE_ENTRIES];
   logic          used_mem [TABLE_ENTRIES];
   logic [31:0]   base_rd_ff;
   logic [31:0]   size_rd_ff;
   logic          used_rd_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          we_base, we_size, we_used;
   logic [31:0]   wr_base, wr_size;
   logic          wr_used;

   logic          req_accept;
   logic          out_free;
   logic          hit;
   logic [32:0]   new_break;
   logic          table_full;
   logic          heap_over;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The single compare unit: tests the entry read last cycle against the
   // request. A free matches on base address alone, whatever the in-use flag.
   always_comb begin
      if (mode_ff == MODE_FREE) begin
         hit = pend_ff && (base_rd_ff == free_addr_ff);
      end else begin
         hit = pend_ff && !used_rd_ff && (size_rd_ff >= req_size_ff);
      end
   end

   // The break is advanced without wrap, so the limit check sees overflow.
   assign new_break  = {1'b0, break_ff} + {1'b0, req_size_ff};
   assign table_full = (count_ff == FULL_COUNT);
   assign heap_over  = (new_break > {1'b0, heap_limit_ff});

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_size_in   = req_size_ff;
      free_addr_in  = free_addr_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      break_in      = break_ff;
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[AW-1:0];
      wr_addr       = pend_idx_ff;
      we_base       = 1'b0;
      we_size       = 1'b0;
      we_used       = 1'b0;
      wr_base       = break_ff;
      wr_size       = req_size_ff;
      wr_used       = 1'b1;

      // Configuration writes are to arrive only while the block is idle; the block does not enforce it.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_BASE: begin
               heap_base_in = csr_write_data;
               if (count_ff == '0) begin
                  break_in = csr_write_data;
               end
            end
            CSR_HEAP_LIMIT: begin
               heap_limit_in = csr_write_data;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in      = req_data.mode;
               req_size_in  = 32'(req_data.element_size) * 32'(req_data.element_count);
               free_addr_in = req_data.block_address;
               scan_in      = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // First match: update it in place and finish.
               wr_addr = pend_idx_ff;
               we_used = 1'b1;
               if (mode_ff == MODE_FREE) begin
                  wr_used = 1'b0;
                  res_in  = '{granted_address: '0, status: STATUS_OK};
               end else begin
                  wr_used = 1'b1;
                  we_size = 1'b1;
                  res_in  = '{granted_address: base_rd_ff, status: STATUS_OK};
               end
               state_in = ST_DONE;
            end else if (scan_ff < count_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + 1'b1;
            end else if (mode_ff == MODE_FREE) begin
               res_in   = '{granted_address: '0, status: STATUS_NOT_FOUND};
               state_in = ST_DONE;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (table_full || heap_over) begin
               res_in = '{granted_address: '0, status: STATUS_NO_SPACE};
            end else begin
               wr_addr  = count_ff[AW-1:0];
               we_base  = 1'b1;
               we_size  = 1'b1;
               we_used  = 1'b1;
               wr_used  = 1'b1;
               count_in = count_ff + 1'b1;
               break_in = new_break[31:0];
               res_in   = '{granted_address: break_ff, status: STATUS_OK};
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold the result until the output register can take it.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         count_ff      <= '0;
         break_ff      <= '0;
         heap_base_ff  <= '0;
         heap_limit_ff <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
         break_ff      <= break_in;
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      req_size_ff  <= req_size_in;
      free_addr_ff <= free_addr_in;
      scan_ff      <= scan_in;
      pend_idx_ff  <= pend_idx_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (we_base) begin
         base_mem[wr_addr] <= wr_base;
      end
      if (we_size) begin
         size_mem[wr_addr] <= wr_size;
      end
      if (we_used) begin
         used_mem[wr_addr] <= wr_used;
      end
      if (rd_en) begin
         base_rd_ff <= base_mem[rd_addr];
         size_rd_ff <= size_mem[rd_addr];
         used_rd_ff <= used_mem[rd_addr];
      end
   end

endmodule

[test/tb_first_fit_block_allocator.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_first_fit_block_allocator: self-checking bench for the block allocator
// Drives allocate and free beats into the allocator and keeps a shadow copy
// of the block table and break pointer. Each response beat is compared with
// the grant that the shadow copy predicts. Heap limits move from phase to
// phase. Both sides idle at random, and the receiver holds off long enough
// at times to back the block up.
// ---------------------------------------------------------------------------
module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   localparam int TABLE_ENTRIES    = TABLE_ENTRIES_DEFAULT;
   // A slow but correct run stays well under a fifth of this limit.
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int LONG_HOLD_CYCLES = 300;

   // The heap shadow mirrors the allocator's table, break pointer and
   // registers. It queues one expected grant per accepted request beat.
   class heap_shadow;
      logic [31:0] heap_base_reg;
      logic [31:0] heap_limit_reg;
      logic [31:0] break_ptr;
      logic [31:0] blk_base [TABLE_ENTRIES];
      logic [31:0] blk_size [TABLE_ENTRIES];
      bit          blk_used [TABLE_ENTRIES];
      int unsigned blk_count;
      rsp_type     expected_grants [$];
      int unsigned failures;

      function new();
         heap_base_reg  = '0;
         heap_limit_reg = '1;
         break_ptr      = '0;
         blk_count      = 0;
         failures       = 0;
      endfunction

      function void store_register(logic [CSR_INDEX_W-1:0] index, logic [31:0] value);
         if (index == CSR_HEAP_BASE) begin
            heap_base_reg = value;
            // The break follows heap_base only while the table is empty.
            if (blk_count == 0) break_ptr = value;
         end else if (index == CSR_HEAP_LIMIT) begin
            heap_limit_reg = value;
         end
      endfunction

      function rsp_type allocate(logic [31:0] bytes);
         rsp_type     grant;
         logic [32:0] next_break;
         grant.granted_address = '0;
         grant.status          = STATUS_NO_SPACE;
         for (int i = 0; i < blk_count; i++) begin
            if (!blk_used[i] && blk_size[i] >= bytes) begin
               blk_used[i]           = 1'b1;
               blk_size[i]           = bytes;
               grant.granted_address = blk_base[i];
               grant.status          = STATUS_OK;
               return grant;
            end
         end
         // A miss appends at the break; the limit check must not wrap.
         next_break = {1'b0, break_ptr} + {1'b0, bytes};
         if (blk_count < TABLE_ENTRIES && next_break <= {1'b0, heap_limit_reg}) begin
            blk_base[blk_count]   = break_ptr;
            blk_size[blk_count]   = bytes;
            blk_used[blk_count]   = 1'b1;
            blk_count++;
            grant.granted_address = break_ptr;
            grant.status          = STATUS_OK;
            break_ptr             = next_break[31:0];
         end
         return grant;
      endfunction

      function rsp_type release_block(logic [31:0] address);
         rsp_type grant;
         grant.granted_address = '0;
         grant.status          = STATUS_NOT_FOUND;
         for (int i = 0; i < blk_count; i++) begin
            if (blk_base[i] == address) begin
               blk_used[i]  = 1'b0;
               grant.status = STATUS_OK;
               return grant;
            end
         end
         return grant;
      endfunction

      function void note_request(req_type beat);
         logic [31:0] bytes;
         if (beat.mode == MODE_ALLOC) begin
            bytes = 32'(beat.element_size) * 32'(beat.element_count);
            expected_grants.push_back(allocate(bytes));
         end else begin
            expected_grants.push_back(release_block(beat.block_address));
         end
      endfunction

      function void check_grant(rsp_type got);
         rsp_type expected_beat;
         if (expected_grants.size() == 0) begin
            $error("unexpected response beat: granted_address %h, status %0d",
                   got.granted_address, got.status);
            failures++;
            return;
         end
         expected_beat = expected_grants.pop_front();
         if (got.granted_address !== expected_beat.granted_address) begin
            $error("granted_address: expected %h, actual %h",
                   expected_beat.granted_address, got.granted_address);
            failures++;
         end
         if (got.status !== expected_beat.status) begin
            $error("status: expected %0d, actual %0d", expected_beat.status, got.status);
            failures++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_grants.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   heap_shadow  shadow        = new();
   int unsigned cycle_count   = 0;
   // When idle_on is clear, both sides run back to back with no gaps.
   bit          idle_on       = 1'b1;
   // Each step of hold_requests makes the receiver stall its next beat for
   // a long stretch while the sender keeps offering requests. Only the
   // stimulus writes it; the receiver counts the holds it has served.
   int unsigned hold_requests = 0;

   first_fit_block_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The clock runs with a 4 ns period, 2 ns high and 2 ns low.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_first_fit_block_allocator: done, errors");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge. Inputs only move at the
   // falling edge, so every value read here is settled. A request beat that
   // is accepted updates the shadow. A response beat that is accepted is
   // checked against the oldest expected grant.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) shadow.note_request(req_data);
         if (rsp_valid && !rsp_stall) shadow.check_grant(rsp_data);
      end
   end

   // The receiver draws a random wait for each response beat while idle_on is
   // set. On request it instead holds off for a long stretch, counted here.
   initial begin : response_sink
      int unsigned pause;
      int unsigned holds_done;
      holds_done = 0;
      wait (reset == 1'b0);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            pause = LONG_HOLD_CYCLES;
         end else begin
            pause = idle_on ? $urandom_range(0, 8) : 0;
         end
         repeat (pause) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // A request beat is offered after a random gap. The beat is held
   // unchanged until an edge accepts it. Valid stays high afterward, so a
   // following beat with no gap goes out back to back.
   task automatic send_request(input req_type beat);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // This task drops valid and waits until every expected grant has come
   // back. The allocator is idle after that.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // Registers are written only once the allocator is idle.
   task automatic program_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow.store_register(index, value);
   endtask

   function automatic req_type make_request(logic mode, logic [15:0] element_size,
                                            logic [15:0] element_count,
                                            logic [31:0] block_address);
      req_type beat;
      beat.mode          = mode;
      beat.element_size  = element_size;
      beat.element_count = element_count;
      beat.block_address = block_address;
      return beat;
   endfunction

   // Most random beats are small allocations and frees of blocks that are
   // really in the table, so entries get reused and shrunk over and over.
   // The rest are huge allocations, frees of near-miss addresses and beats
   // that are random in every field.
   function automatic req_type random_request();
      req_type     beat;
      logic [31:0] noise;
      int unsigned pick;
      pick               = $urandom_range(0, 99);
      noise              = $urandom;
      beat.mode          = MODE_ALLOC;
      beat.element_size  = noise[15:0];
      beat.element_count = noise[31:16];
      beat.block_address = $urandom;
      if (pick < 45) begin
         noise              = $urandom_range(0, 64);
         beat.element_size  = noise[15:0];
         noise              = $urandom_range(0, 12);
         beat.element_count = noise[15:0];
      end else if (pick < 50) begin
         // This is a full-range allocation; the random fields stay as drawn.
      end else if (pick < 85 && shadow.blk_count != 0) begin
         beat.mode          = MODE_FREE;
         noise              = $urandom_range(0, shadow.blk_count - 1);
         beat.block_address = shadow.blk_base[noise];
      end else if (pick < 92 && shadow.blk_count != 0) begin
         beat.mode          = MODE_FREE;
         noise              = $urandom_range(0, shadow.blk_count - 1);
         beat.block_address = shadow.blk_base[noise] + $urandom_range(1, 3);
      end else begin
         noise     = $urandom;
         beat.mode = noise[0];
      end
      return beat;
   endfunction

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Freeing anything in an empty table reports the address as unknown.
      // The break is parked at the top of memory meanwhile.
      program_register(CSR_HEAP_BASE, 32'hFFFF_FFFF);
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'hFFFF_FFFF));

      // With a zero limit, even a zero-size allocation at the break fails.
      program_register(CSR_HEAP_BASE, 32'h0000_1000);
      program_register(CSR_HEAP_LIMIT, 32'h0000_0000);
      send_request(make_request(MODE_ALLOC, 16'h0000, 16'h0000, 32'h0000_0000));
      send_request(make_request(MODE_ALLOC, 16'h0001, 16'h0001, 32'h0000_0000));

      program_register(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      // A zero-size block sits at the break, and the next block shares its
      // base.
      send_request(make_request(MODE_ALLOC, 16'hFFFF, 16'h0000, 32'h0000_0000));
      send_request(make_request(MODE_ALLOC, 16'h0010, 16'h0004, 32'h0000_0000));
      // A free hits the first matching base. Freeing it twice is harmless.
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'h0000_1000));
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'h0000_1000));
      // The largest product fits once. The second try would wrap 32 bits
      // and must fail.
      send_request(make_request(MODE_ALLOC, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
      send_request(make_request(MODE_ALLOC, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
      // After the huge block is freed it is reused and shrinks to 21 bytes.
      // A 22-byte request then misses it.
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'h0000_1040));
      send_request(make_request(MODE_ALLOC, 16'h0003, 16'h0007, 32'h0000_0000));
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'h0000_1040));
      send_request(make_request(MODE_ALLOC, 16'h0002, 16'h000B, 32'h0000_0000));
      // A zero-size request takes the first free entry of any size.
      send_request(make_request(MODE_ALLOC, 16'h0000, 16'h0005, 32'h0000_0000));
      send_request(make_request(MODE_FREE, 16'h0000, 16'h0000, 32'h0000_0000));
      // The fields that the mode ignores carry all ones here.
      send_request(make_request(MODE_FREE, 16'hFFFF, 16'hFFFF, 32'h0000_1040));
      send_request(make_request(MODE_ALLOC, 16'h0001, 16'h0015, 32'hFFFF_FFFF));

      // The limit sits a little above the break, so appends soon run out of
      // heap. A long receiver hold backs the block up partway through.
      program_register(CSR_HEAP_LIMIT, shadow.break_ptr + 32'd3000);
      for (int n = 0; n < 250; n++) begin
         if (n == 120) hold_requests++;
         send_request(random_request());
      end

      // The limit equals the break, so only zero-size appends still fit.
      // Nothing idles in this phase.
      idle_on = 1'b0;
      program_register(CSR_HEAP_LIMIT, shadow.break_ptr);
      for (int n = 0; n < 250; n++) send_request(random_request());

      // With a zero limit, only reuse of free entries can succeed.
      idle_on = 1'b1;
      program_register(CSR_HEAP_LIMIT, 32'h0000_0000);
      for (int n = 0; n < 250; n++) send_request(random_request());

      // The table is no longer empty, so heap_base is stored and the break
      // stays put. With the limit wide open, the table fills to the top.
      program_register(CSR_HEAP_BASE, $urandom);
      program_register(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      for (int n = 0; n < 1100; n++) begin
         if (n == 300) hold_requests++;
         if (n == 600) drain();
         idle_on = !(n >= 800 && n < 950);
         send_request(random_request());
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.failures == 0) begin
         $display("tb_first_fit_block_allocator: done, clean");
      end else begin
         $display("tb_first_fit_block_allocator: done, errors");
      end
      $finish;
   end

endmodule
